### src/fmp_pkg.sv
`default_nettype none
package fmp_pkg;

  // Width of the modulus exponent field
  localparam int MOD_FIELD_W = 5;

  // Multiplier digit: bits of the multiplier consumed per cycle
  localparam int DIGIT_W = 4;

endpackage
`default_nettype wire

### src/fmp_mul.sv
`default_nettype none
module fmp_mul #(
  parameter int WIDTH = 31
) (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic [WIDTH-1:0] x,
  input  wire logic [WIDTH-1:0] y,
  output logic      [WIDTH-1:0] prod
);
  import fmp_pkg::*;

  localparam int NUM_DIGITS = (WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int Y_W        = NUM_DIGITS * DIGIT_W;

  logic [WIDTH-1:0]         x_r, x_nxt;
  logic [Y_W-1:0]           y_r, y_nxt;
  logic [WIDTH-1:0]         p_r, p_nxt;
  logic [WIDTH+DIGIT_W-1:0] part;

  // Multiply the shifted multiplicand by the lowest multiplier digit
  assign part = {{DIGIT_W{1'b0}}, x_r} * {{WIDTH{1'b0}}, y_r[DIGIT_W-1:0]};

  // Load operands, or accumulate one digit and advance both shifters
  always_comb begin
    if (load) begin
      x_nxt = x;
      y_nxt = Y_W'(y);
      p_nxt = '0;
    end else begin
      x_nxt = x_r << DIGIT_W;
      y_nxt = y_r >> DIGIT_W;
      p_nxt = p_r + part[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    p_r <= p_nxt;
  end

  assign prod = p_r;

endmodule
`default_nettype wire

### src/fibonacci_mod_pow2_top.sv
// Fibonacci number modulo a power of two.
// Input channel (in_valid/in_ready) carries an index n and an exponent m;
// the result channel (out_valid/out_ready) returns F(n) mod 2^m, with
// F(0)=0, F(1)=1, and 0 when m is 0. An exponent above MOD_BITS_MAX
// saturates to MOD_BITS_MAX.
// The index is walked bit by bit from the top with fast doubling on the
// pair (F(k+1), F(k)). Each round runs three digit-serial multipliers in
// parallel, DIGIT_W multiplier bits per cycle, in the states S_LOAD, S_MUL
// and S_UPD, one round per index bit; S_FIN then posts the result. One
// item is in work at a time, so a new item is accepted only once the last
// one has left S_FIN; the multiplier round loop sets the rate.
// The result sits in an output register, so the next item is accepted
// while an earlier result waits for out_ready. If the receiver stalls and
// a second result is finished, the block holds it and stops accepting.
// Reset (rst_n low, synchronous) drops any item in work and any result
// not yet taken; the block then waits for input.
`default_nettype none
module fibonacci_mod_pow2_top #(
  parameter int INDEX_BITS   = 31,
  parameter int MOD_BITS_MAX = 31
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [INDEX_BITS-1:0]   in_fib_index,
  input  wire logic [4:0]              in_mod_bits,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic      [MOD_BITS_MAX-1:0] out_fib_value
);
  import fmp_pkg::*;

  localparam int W          = MOD_BITS_MAX;
  localparam int NUM_DIGITS = (W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIG_CNT_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int BIT_CNT_W  = $clog2(INDEX_BITS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_MUL  = 5'b00100,
    S_UPD  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [INDEX_BITS-1:0]  e_r, e_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic [MOD_FIELD_W-1:0] m_r, m_nxt;
  logic                   zero_r, zero_nxt;
  logic [W-1:0]           a_r, a_nxt;
  logic [W-1:0]           b_r, b_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [W-1:0]           out_val_r, out_val_nxt;

  logic                   accept;
  logic                   mul_load;
  logic [W-1:0]           two_a_minus_b;
  logic [W-1:0]           p_cross, p_aa, p_bb;
  logic [W-1:0]           f_even, f_odd;
  logic [W-1:0]           mask;
  logic                   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_fib_value = out_val_r;
  assign out_free  = !out_valid_r || out_ready;
  assign mul_load  = (state_r == S_LOAD);

  // F(2k) = F(k) * (2F(k+1) - F(k)), F(2k+1) = F(k+1)^2 + F(k)^2
  assign two_a_minus_b = (a_r << 1) - b_r;

  fmp_mul #(.WIDTH(W)) u_mul_cross (
    .clk(clk), .load(mul_load), .x(b_r), .y(two_a_minus_b), .prod(p_cross)
  );
  fmp_mul #(.WIDTH(W)) u_mul_aa (
    .clk(clk), .load(mul_load), .x(a_r), .y(a_r), .prod(p_aa)
  );
  fmp_mul #(.WIDTH(W)) u_mul_bb (
    .clk(clk), .load(mul_load), .x(b_r), .y(b_r), .prod(p_bb)
  );

  assign f_even = p_cross;
  assign f_odd  = p_aa + p_bb;

  // Keep the low m bits of the result
  always_comb begin
    for (int i = 0; i < W; i++) begin
      mask[i] = (i < int'(m_r));
    end
  end

  // Sequence the rounds over the index bits
  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    m_nxt         = m_r;
    zero_nxt      = zero_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          e_nxt       = in_fib_index - INDEX_BITS'(1);
          zero_nxt    = (in_fib_index == '0);
          m_nxt       = (in_mod_bits > MOD_FIELD_W'(MOD_BITS_MAX)) ?
                        MOD_FIELD_W'(MOD_BITS_MAX) : in_mod_bits;
          a_nxt       = W'(1);
          b_nxt       = '0;
          bit_cnt_nxt = BIT_CNT_W'(INDEX_BITS - 1);
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        dig_cnt_nxt = '0;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        dig_cnt_nxt = dig_cnt_r + DIG_CNT_W'(1);
        if (dig_cnt_r == DIG_CNT_W'(NUM_DIGITS - 1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // Double, then step once more if the index bit is set
        if (e_r[INDEX_BITS-1]) begin
          a_nxt = f_even + f_odd;
          b_nxt = f_odd;
        end else begin
          a_nxt = f_odd;
          b_nxt = f_even;
        end
        e_nxt = e_r << 1;
        if (bit_cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
          state_nxt   = S_LOAD;
        end
      end
      S_FIN: begin
        // Hold the finished value until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = zero_r ? '0 : (a_r & mask);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r       <= e_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    dig_cnt_r <= dig_cnt_nxt;
    m_r       <= m_nxt;
    zero_r    <= zero_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    out_val_r <= out_val_nxt;
  end

endmodule
`default_nettype wire

### src/fmp_checker.sv
`default_nettype none
module fmp_checker #(
  parameter int INDEX_BITS   = 31,
  parameter int MOD_BITS_MAX = 31
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic [INDEX_BITS-1:0]   in_fib_index,
  input wire logic [4:0]              in_mod_bits,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [MOD_BITS_MAX-1:0] out_fib_value
);

  // Leaving reset, the block is empty and waits for input
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fib_value))
    else $error("stalled result changed");

  // A waiting input item holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=>
      in_valid && $stable(in_fib_index) && $stable(in_mod_bits))
    else $error("waiting input item changed");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  // A new result appears only as the block returns to waiting for input
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result posted while work still under way");

endmodule

bind fibonacci_mod_pow2_top fmp_checker #(
  .INDEX_BITS(INDEX_BITS),
  .MOD_BITS_MAX(MOD_BITS_MAX)
) u_fmp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .in_fib_index(in_fib_index),
  .in_mod_bits(in_mod_bits),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_fib_value(out_fib_value)
);
`default_nettype wire

### dv/fibonacci_mod_pow2_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module fibonacci_mod_pow2_top_tb;
  import fmp_pkg::*;

  localparam int INDEX_W     = 31;
  localparam int VALUE_W     = 31;
  localparam int MOD_MAX     = 31;
  localparam int N_ITEMS     = 850;
  localparam int DRAIN       = 400;
  localparam int CYCLE_LIMIT = 2_500_000;

  typedef struct packed {
    bit [31:0] e00;
    bit [31:0] e01;
    bit [31:0] e10;
    bit [31:0] e11;
  } mat2_t;

  typedef struct {
    bit [INDEX_W-1:0]     fib_index;
    bit [MOD_FIELD_W-1:0] mod_bits;
    bit [VALUE_W-1:0]     fib_value;
  } fib_expect_t;

  class fib_scoreboard;
    fib_expect_t pending_fib[$];
    int unsigned compared;
    int unsigned mismatches;

    function new();
      compared   = 0;
      mismatches = 0;
    endfunction

    // 2x2 product, every entry wrapping at 32 bits
    function mat2_t mat_product(mat2_t x, mat2_t y);
      mat2_t r;
      r.e00 = x.e00 * y.e00 + x.e01 * y.e10;
      r.e01 = x.e00 * y.e01 + x.e01 * y.e11;
      r.e10 = x.e10 * y.e00 + x.e11 * y.e10;
      r.e11 = x.e10 * y.e01 + x.e11 * y.e11;
      return r;
    endfunction

    // F(n) mod 2^32 by raising the step matrix to n-1, top bit first
    function bit [31:0] fib_low_word(bit [INDEX_W-1:0] n);
      mat2_t     acc;
      mat2_t     step;
      bit [31:0] e;
      if (n == 0) return 32'd0;
      e    = 32'(n) - 32'd1;
      acc  = '{32'd1, 32'd0, 32'd0, 32'd1};
      step = '{32'd1, 32'd1, 32'd1, 32'd0};
      for (int b = INDEX_W - 1; b >= 0; b--) begin
        acc = mat_product(acc, acc);
        if (e[b]) acc = mat_product(acc, step);
      end
      return acc.e00;
    endfunction

    // Reduce to the low m bits; m saturates at the widest modulus
    function bit [VALUE_W-1:0] fib_mod_pow2(bit [INDEX_W-1:0] n, bit [MOD_FIELD_W-1:0] m);
      bit [63:0] mask;
      bit [31:0] word;
      int        mb;
      mb   = (m > MOD_MAX) ? MOD_MAX : int'(m);
      mask = (64'd1 << mb) - 64'd1;
      word = fib_low_word(n) & mask[31:0];
      return word[VALUE_W-1:0];
    endfunction

    function void note_item(bit [INDEX_W-1:0] n, bit [MOD_FIELD_W-1:0] m);
      fib_expect_t x;
      x.fib_index = n;
      x.mod_bits  = m;
      x.fib_value = fib_mod_pow2(n, m);
      pending_fib.insert(pending_fib.size(), x);
    endfunction

    function void check_item(bit [VALUE_W-1:0] got);
      fib_expect_t x;
      if (pending_fib.size() == 0) begin
        $display("%0t: unexpected fib_value 0x%0h with no item pending", $time, got);
        mismatches++;
        return;
      end
      x = pending_fib.pop_front();
      compared++;
      if (got !== x.fib_value) begin
        $display("%0t: fib_value mismatch n=%0d m=%0d: expected 0x%0h, actual 0x%0h",
                 $time, x.fib_index, x.mod_bits, x.fib_value, got);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk           = 1'b0;
  logic                   rst_n         = 1'b0;
  logic                   in_valid      = 1'b0;
  logic                   in_ready;
  logic [INDEX_W-1:0]     in_fib_index  = '0;
  logic [MOD_FIELD_W-1:0] in_mod_bits   = '0;
  logic                   out_valid;
  logic                   out_ready     = 1'b0;
  logic [VALUE_W-1:0]     out_fib_value;

  fib_scoreboard sb = new();
  bit            steady = 1'b0;
  int unsigned   cycle_count = 0;
  int            stall_left = 0;
  int            sent = 0;

  fibonacci_mod_pow2_top #(
    .INDEX_BITS   (INDEX_W),
    .MOD_BITS_MAX (MOD_MAX)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_fib_index  (in_fib_index),
    .in_mod_bits   (in_mod_bits),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_fib_value (out_fib_value)
  );

  always #1 clk = ~clk;

  // Mostly short idle spans, now and then a long one
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 30);
    return $urandom_range(60, 200);
  endfunction

  function automatic bit [INDEX_W-1:0] rand_index();
    bit [INDEX_W-1:0] n;
    int               r;
    r = $urandom_range(0, 9);
    n = INDEX_W'($urandom());
    case (r)
      0, 1, 2: n = INDEX_W'($urandom_range(0, 120));
      3: n = INDEX_W'((1 << $urandom_range(0, INDEX_W - 1)) + $urandom_range(0, 2) - 1);
      4: n = {INDEX_W{1'b1}} - INDEX_W'($urandom_range(0, 15));
      default: ;
    endcase
    return n;
  endfunction

  function automatic bit [MOD_FIELD_W-1:0] rand_mod();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return MOD_FIELD_W'(MOD_MAX);
    if (r < 25) return '0;
    return MOD_FIELD_W'($urandom_range(0, 31));
  endfunction

  // Present one item after a random gap and hold it until accepted
  task automatic send_item(bit [INDEX_W-1:0] n, bit [MOD_FIELD_W-1:0] m);
    int gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_fib_index <= n;
    in_mod_bits  <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Stall the result side at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left = idle_span() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watch both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_item(out_fib_value);
      if (in_valid && in_ready) sb.note_item(in_fib_index, in_mod_bits);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, sb.pending_fib.size());
      $display("fibonacci_mod_pow2_top_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: index and exponent extremes, wraparound past 32 bits
    send_item(31'd0, 5'd31);
    send_item(31'd0, 5'd0);
    send_item(31'd1, 5'd0);
    send_item(31'd1, 5'd1);
    send_item(31'd1, 5'd31);
    send_item(31'd2, 5'd31);
    send_item(31'd3, 5'd1);
    send_item(31'd10, 5'd4);
    send_item(31'd46, 5'd31);
    send_item(31'd47, 5'd31);
    send_item(31'd48, 5'd31);
    send_item(31'd93, 5'd16);
    send_item(31'h7fffffff, 5'd31);
    send_item(31'h7fffffff, 5'd0);
    send_item(31'h7fffffff, 5'd5);
    send_item(31'h40000000, 5'd31);
    send_item(31'h3fffffff, 5'd30);
    send_item(31'h55555555, 5'd21);
    send_item(31'h2aaaaaaa, 5'd10);
    send_item(31'd1000000, 5'd8);

    // Random: blocks of 50 items, every fourth block without idling
    for (int i = 0; sent < N_ITEMS; i++) begin
      steady = ((i / 50) % 4 == 3);
      send_item(rand_index(), rand_mod());
    end
    in_valid <= 1'b0;
    steady = 1'b1;

    // Drain, then give stray results time to show up
    while (sb.pending_fib.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("sent %0d items: index and exponent extremes, wrap past 32 bits, random indices",
             sent);
    $display("compared %0d results with idle gaps and stalls on both sides", sb.compared);
    if (sb.mismatches == 0) begin
      $display("fibonacci_mod_pow2_top_tb: clean");
    end else begin
      $display("fibonacci_mod_pow2_top_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
